>>> hw/rtl/playfair_digraph_encrypt_assert.svh
// Assertion macros shared by the Playfair encryptor checkers.
// Requires clk and rst to be visible where the macros are used.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_ASSERT_SVH

// Antecedent in one cycle implies consequent in the next, outside reset.
`define PFDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfde check failed");

// A cycle in reset implies the consequent in the following cycle.
`define PFDE_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("pfde reset check failed");

`endif

>>> hw/rtl/pfde_pkg.sv
// Shared types, codes and cell arithmetic for the Playfair encryptor.
// Used by pfde_store, playfair_digraph_encrypt and pfde_checker.
package pfde_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] idx_t;

  localparam letter_t LETTER_I      = 5'd8;
  localparam letter_t LETTER_J      = 5'd9;
  localparam letter_t LAST_LETTER   = 5'd25;
  localparam letter_t FILLER_RESET  = 5'd23;
  localparam letter_t ALT_RESET     = 5'd25;
  localparam cell_t   CELLS         = 5'd25;
  localparam idx_t    SIDE_LAST     = 3'd4;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_KEY      = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_PLAIN    = 2'd3
  } op_t;

  localparam logic CFG_FILLER = 1'b0;
  localparam logic CFG_ALT    = 1'b1;

  // Commands from the sequencer to the square storage.
  typedef struct packed {
    logic    clear;
    logic    wr_en;
    letter_t wr_letter;
    cell_t   wr_cell;
    letter_t pos_rd_letter;
    cell_t   sq_rd_cell;
    letter_t probe_letter;
  } store_cmd_t;

  // Responses from the square storage.
  typedef struct packed {
    cell_t   pos_cell;
    logic    pos_present;
    letter_t sq_letter;
    logic    probe_present;
  } store_rsp_t;

  typedef struct packed {
    cell_t a;
    cell_t b;
  } cell_pair_t;

  // Out-of-range letters act as z, and j acts as i.
  function automatic letter_t fold_letter(letter_t v);
    letter_t r;
    if (v > LAST_LETTER) r = LAST_LETTER;
    else if (v == LETTER_J) r = LETTER_I;
    else r = v;
    return r;
  endfunction

  // Filler placed after a letter; the alternate is used next to the filler itself.
  function automatic letter_t filler_for(letter_t l, letter_t fill, letter_t alt);
    letter_t f;
    f = fold_letter(fill);
    return (l == f) ? fold_letter(alt) : f;
  endfunction

  function automatic idx_t row_of(cell_t p);
    idx_t r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic cell_t cell_at(idx_t r, idx_t c);
    cell_t base;
    base = cell_t'(r) * cell_t'(5);
    return base + cell_t'(c);
  endfunction

  function automatic idx_t col_of(cell_t p);
    cell_t d;
    d = p - cell_at(row_of(p), 3'd0);
    return d[2:0];
  endfunction

  function automatic idx_t next_idx(idx_t i);
    return (i == SIDE_LAST) ? 3'd0 : i + 3'd1;
  endfunction

  // Target cells of a digraph by the row, column and rectangle rules.
  function automatic cell_pair_t cipher_cells(cell_t pa, cell_t pb);
    idx_t r1, c1, r2, c2;
    cell_pair_t res;
    r1 = row_of(pa);
    c1 = col_of(pa);
    r2 = row_of(pb);
    c2 = col_of(pb);
    if (r1 == r2) begin
      res.a = cell_at(r1, next_idx(c1));
      res.b = cell_at(r2, next_idx(c2));
    end else if (c1 == c2) begin
      res.a = cell_at(next_idx(r1), c1);
      res.b = cell_at(next_idx(r2), c2);
    end else begin
      res.a = cell_at(r1, c2);
      res.b = cell_at(r2, c1);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/playfair_digraph_encrypt.sv
// Playfair digraph encryptor, one item at a time under a sequencer.
// Clear and key letter are handled in the idle state; complete square walks 26 letters.
// A plaintext letter runs fill, char, pad and finish, a push per buffered letter
// and per digraph two position reads, two square reads, two output loads, plus stalls.
// Digraph time is set by the single read port of each square memory.
// Reset (synchronous, rst high): square empty, no pending letter, fillers x and z.
module playfair_digraph_encrypt (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [4:0] letter,
  input  logic       message_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] cipher_letter,
  output logic       last_of_message,
  input  logic       cfg_write_enable,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_FILL, S_CHAR, S_PAD, S_FINISH, S_PUSH,
    S_POS_A, S_POS_B, S_MAP, S_KEY_A, S_KEY_B, S_EMIT_A, S_EMIT_B
  } state_t;

  state_t                state;
  state_t                push_ret;
  pfde_pkg::letter_t     walk_letter;
  pfde_pkg::cell_t       fill_count;
  pfde_pkg::letter_t     pend_letter;
  logic                  pend_valid;
  pfde_pkg::letter_t     prev_letter;
  logic                  prev_valid;
  pfde_pkg::letter_t     cur_letter;
  logic                  cur_ok;
  logic                  cur_end;
  pfde_pkg::letter_t     push_letter;
  logic                  push_last;
  pfde_pkg::cell_t       pos_a;
  logic                  pos_a_ok;
  logic                  enc;
  pfde_pkg::cell_t       cell_b;
  pfde_pkg::letter_t     out_a;
  pfde_pkg::letter_t     out_b;
  pfde_pkg::letter_t     filler_letter;
  pfde_pkg::letter_t     alternate_filler;

  pfde_pkg::store_cmd_t  store_cmd;
  pfde_pkg::store_rsp_t  store_rsp;
  pfde_pkg::cell_pair_t  cells;
  pfde_pkg::letter_t     key_letter;
  logic                  letter_ok;
  logic                  in_fire;
  logic                  out_free;

  pfde_store u_store (
    .clk (clk),
    .rst (rst),
    .cmd (store_cmd),
    .rsp (store_rsp)
  );

  assign in_stall   = (state != S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign key_letter = pfde_pkg::fold_letter(letter);
  assign letter_ok  = (letter <= pfde_pkg::LAST_LETTER);
  assign cells      = pfde_pkg::cipher_cells(pos_a, store_rsp.pos_cell);

  // Storage commands follow the sequencer state.
  always_comb begin
    store_cmd               = '0;
    store_cmd.clear         = in_fire && (operation == pfde_pkg::OP_CLEAR);
    store_cmd.probe_letter  = (state == S_WALK) ? walk_letter : key_letter;
    store_cmd.wr_cell       = fill_count;
    store_cmd.wr_letter     = store_cmd.probe_letter;
    store_cmd.pos_rd_letter = (state == S_POS_A) ? pend_letter : push_letter;
    store_cmd.sq_rd_cell    = (state == S_MAP) ? cells.a : cell_b;
    if (state == S_WALK) begin
      store_cmd.wr_en = (walk_letter != pfde_pkg::LETTER_J) &&
                        (fill_count < pfde_pkg::CELLS) && !store_rsp.probe_present;
    end else begin
      store_cmd.wr_en = in_fire && (operation == pfde_pkg::OP_KEY) && letter_ok &&
                        (fill_count < pfde_pkg::CELLS) && !store_rsp.probe_present;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filler_letter    <= pfde_pkg::FILLER_RESET;
      alternate_filler <= pfde_pkg::ALT_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        pfde_pkg::CFG_FILLER: filler_letter    <= cfg_data;
        pfde_pkg::CFG_ALT:    alternate_filler <= cfg_data;
        default:              filler_letter    <= filler_letter;
      endcase
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      pend_valid <= 1'b0;
      prev_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // The emit states load the output register themselves.
      if (out_valid && !out_stall && (state != S_EMIT_A) && (state != S_EMIT_B)) begin
        out_valid <= 1'b0;
      end
      if (store_cmd.wr_en) begin
        fill_count <= fill_count + 5'd1;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (pfde_pkg::op_t'(operation))
              pfde_pkg::OP_CLEAR: begin
                fill_count <= '0;
                pend_valid <= 1'b0;
                prev_valid <= 1'b0;
              end
              pfde_pkg::OP_KEY: begin
                state <= S_IDLE;
              end
              pfde_pkg::OP_COMPLETE: begin
                walk_letter <= '0;
                state       <= S_WALK;
              end
              pfde_pkg::OP_PLAIN: begin
                cur_letter <= key_letter;
                cur_ok     <= letter_ok;
                cur_end    <= message_end;
                state      <= S_FILL;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_WALK: begin
          if (walk_letter == pfde_pkg::LAST_LETTER) begin
            state <= S_IDLE;
          end else begin
            walk_letter <= walk_letter + 5'd1;
          end
        end
        // Insert a filler between two equal adjacent letters.
        S_FILL: begin
          if (cur_ok && prev_valid && (prev_letter == cur_letter)) begin
            push_letter <= pfde_pkg::filler_for(cur_letter, filler_letter, alternate_filler);
            push_last   <= 1'b0;
            push_ret    <= S_CHAR;
            state       <= S_PUSH;
          end else begin
            state <= S_CHAR;
          end
        end
        S_CHAR: begin
          if (cur_ok) begin
            prev_letter <= cur_letter;
            prev_valid  <= 1'b1;
            push_letter <= cur_letter;
            push_last   <= cur_end;
            push_ret    <= S_PAD;
            state       <= S_PUSH;
          end else begin
            state <= S_PAD;
          end
        end
        // Pad an odd message at its end.
        S_PAD: begin
          if (cur_end && pend_valid) begin
            push_letter <= pfde_pkg::filler_for(pend_letter, filler_letter, alternate_filler);
            push_last   <= 1'b1;
            push_ret    <= S_FINISH;
            state       <= S_PUSH;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cur_end) begin
            pend_valid <= 1'b0;
            prev_valid <= 1'b0;
          end
          state <= S_IDLE;
        end
        // Hold a first letter, or start a digraph with the held one.
        S_PUSH: begin
          if (!pend_valid) begin
            pend_letter <= push_letter;
            pend_valid  <= 1'b1;
            state       <= push_ret;
          end else begin
            pend_valid <= 1'b0;
            state      <= S_POS_A;
          end
        end
        S_POS_A: begin
          state <= S_POS_B;
        end
        S_POS_B: begin
          pos_a    <= store_rsp.pos_cell;
          pos_a_ok <= store_rsp.pos_present;
          state    <= S_MAP;
        end
        S_MAP: begin
          enc    <= (fill_count == pfde_pkg::CELLS) && pos_a_ok && store_rsp.pos_present;
          cell_b <= cells.b;
          state  <= S_KEY_A;
        end
        S_KEY_A: begin
          out_a <= enc ? store_rsp.sq_letter : pend_letter;
          state <= S_KEY_B;
        end
        S_KEY_B: begin
          out_b <= enc ? store_rsp.sq_letter : push_letter;
          state <= S_EMIT_A;
        end
        S_EMIT_A: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            cipher_letter   <= out_a;
            last_of_message <= 1'b0;
            state           <= S_EMIT_B;
          end
        end
        S_EMIT_B: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            cipher_letter   <= out_b;
            last_of_message <= push_last;
            state           <= push_ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/pfde_store.sv
// Key square storage: square memory, letter position memory and placed bits.
// Depends on pfde_pkg for the command and response structs.
module pfde_store (
  input  logic                  clk,
  input  logic                  rst,
  input  pfde_pkg::store_cmd_t  cmd,
  output pfde_pkg::store_rsp_t  rsp
);

  pfde_pkg::letter_t key_square [25];
  pfde_pkg::cell_t   letter_position [26];
  logic [25:0]       placed;
  pfde_pkg::cell_t   pos_cell;
  logic              pos_present;
  pfde_pkg::letter_t sq_letter;

  // Placed bits stand for the reset value of the position memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      placed      <= '0;
      pos_present <= 1'b0;
    end else begin
      if (cmd.clear) begin
        placed <= '0;
      end else if (cmd.wr_en) begin
        placed[cmd.wr_letter] <= 1'b1;
      end
      pos_present <= placed[cmd.pos_rd_letter];
    end
  end

  // Both memories are written together and read with registered data.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_square[cmd.wr_cell]        <= cmd.wr_letter;
      letter_position[cmd.wr_letter] <= cmd.wr_cell;
    end
    pos_cell  <= letter_position[cmd.pos_rd_letter];
    sq_letter <= key_square[cmd.sq_rd_cell];
  end

  assign rsp.pos_cell      = pos_cell;
  assign rsp.pos_present   = pos_present;
  assign rsp.sq_letter     = sq_letter;
  assign rsp.probe_present = placed[cmd.probe_letter];

endmodule

>>> hw/rtl/pfde_checker.sv
// Port-level checks for the Playfair encryptor and their bind to the top level.
// Depends on pfde_pkg and playfair_digraph_encrypt_assert.svh.
`include "playfair_digraph_encrypt_assert.svh"

module pfde_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] cipher_letter,
  input logic       last_of_message
);

  // A stalled result holds until its transfer.
  `PFDE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cipher_letter) && $stable(last_of_message))

  // Plaintext and completion items keep the input busy in the next cycle.
  `PFDE_ASSERT_NEXT(a_busy_after_long_op, in_valid && !in_stall && (operation == pfde_pkg::OP_PLAIN || operation == pfde_pkg::OP_COMPLETE), in_stall)

  // Reset leaves no result waiting and the input open.
  `PFDE_ASSERT_RESET(a_reset_out, !out_valid)
  `PFDE_ASSERT_RESET(a_reset_idle, !in_stall)

endmodule

bind playfair_digraph_encrypt pfde_checker u_pfde_checker (.*);
